[hw/rtl/b64c_pkg.sv]
// ----------------------------------------------------------------------------
// b64c_pkg
// Types, codes and character mapping functions shared by the base64 stream codec.
// ----------------------------------------------------------------------------
package b64c_pkg;

  localparam int unsigned JOB_RESULTS = 4;
  localparam int unsigned JOB_DEPTH   = 2;
  localparam int unsigned JOB_PTR_W   = $clog2(JOB_DEPTH);
  localparam int unsigned JOB_CNT_W   = $clog2(JOB_DEPTH + 1);
  localparam int unsigned RES_IDX_W   = $clog2(JOB_RESULTS);

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_CHAR = 2'd1;
  localparam logic [1:0] ST_BAD_LEN  = 2'd2;

  localparam logic CFG_DIRECTION = 1'b0;
  localparam logic CFG_VARIANT   = 1'b1;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic VAR_URL    = 1'b1;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic [1:0] status;
  } result_t;

  // all results released by one accepted item
  typedef struct packed {
    logic [2:0]                   cnt;
    result_t [JOB_RESULTS-1:0]    res;
  } job_t;

  function automatic logic [7:0] enc_char(input logic [5:0] s, input logic url);
    if (s < 6'd26) return 8'h41 + {2'b00, s};
    if (s < 6'd52) return 8'h61 + {2'b00, s - 6'd26};
    if (s < 6'd62) return 8'h30 + {2'b00, s - 6'd52};
    if (s == 6'd62) return url ? 8'h2D : 8'h2B;
    return url ? 8'h5F : 8'h2F;
  endfunction

  // bit 6 set when the character is outside the alphabet
  function automatic logic [6:0] dec_val(input logic [7:0] c, input logic url);
    if (c >= 8'h41 && c <= 8'h5A) return {1'b0, 6'(c - 8'h41)};
    if (c >= 8'h61 && c <= 8'h7A) return {1'b0, 6'(c - 8'h61 + 8'd26)};
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, 6'(c - 8'h30 + 8'd52)};
    if (url) begin
      if (c == 8'h2D) return 7'd62;
      if (c == 8'h5F) return 7'd63;
    end else begin
      if (c == 8'h2B) return 7'd62;
      if (c == 8'h2F) return 7'd63;
    end
    return 7'h40;
  endfunction

endpackage

[hw/rtl/b64c_front.sv]
// ----------------------------------------------------------------------------
// b64c_front
// Accepts one beat per cycle while accept is high, keeps the group state and
// builds the job of results that the beat releases.
// ----------------------------------------------------------------------------
module b64c_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr,
  input  logic              cfg_addr,
  input  logic              cfg_wdata,
  input  logic              accept,
  input  b64c_pkg::item_t   item,
  output logic              job_push,
  output b64c_pkg::job_t    job
);

  logic        direction;
  logic        variant;
  logic [23:0] group_bits;
  logic [1:0]  group_count;
  logic        pad_seen;
  logic        discarding;

  logic [23:0] group_bits_next;
  logic [1:0]  group_count_next;
  logic        pad_seen_next;
  logic        discarding_next;

  logic [7:0]  b;
  logic        last;
  logic [2:0]  n;
  logic [23:0] ebits;
  logic [6:0]  dv;
  logic [23:0] dbits;
  logic        err;
  logic [1:0]  err_st;
  logic        emitted;

  assign b    = item.in_byte;
  assign last = item.in_last;

  always_comb begin
    job              = '0;
    group_bits_next  = group_bits;
    group_count_next = group_count;
    pad_seen_next    = pad_seen;
    discarding_next  = discarding;
    err              = 1'b0;
    err_st           = b64c_pkg::ST_OK;
    emitted          = 1'b0;
    n     = {1'b0, group_count} + 3'd1;
    ebits = {group_bits[15:0], b};
    dv    = b64c_pkg::dec_val(b, variant);
    dbits = {group_bits[17:0], dv[5:0]};

    if (discarding) begin
      if (last) begin
        discarding_next  = 1'b0;
        group_bits_next  = '0;
        group_count_next = '0;
        pad_seen_next    = 1'b0;
      end
    end else if (direction == b64c_pkg::DIR_ENCODE) begin
      if (n >= 3'd3) begin
        job.cnt = 3'd4;
        job.res[0] = '{b64c_pkg::enc_char(ebits[23:18], variant), 1'b0, b64c_pkg::ST_OK};
        job.res[1] = '{b64c_pkg::enc_char(ebits[17:12], variant), 1'b0, b64c_pkg::ST_OK};
        job.res[2] = '{b64c_pkg::enc_char(ebits[11:6], variant), 1'b0, b64c_pkg::ST_OK};
        job.res[3] = '{b64c_pkg::enc_char(ebits[5:0], variant), last, b64c_pkg::ST_OK};
        group_bits_next  = '0;
        group_count_next = '0;
        pad_seen_next    = 1'b0;
      end else if (!last) begin
        group_bits_next  = ebits;
        group_count_next = n[1:0];
      end else begin
        if (n == 3'd1) begin
          job.cnt = (variant == b64c_pkg::VAR_URL) ? 3'd2 : 3'd4;
          job.res[0] = '{b64c_pkg::enc_char(ebits[7:2], variant), 1'b0, b64c_pkg::ST_OK};
          job.res[1] = '{b64c_pkg::enc_char({ebits[1:0], 4'b0000}, variant), variant,
                         b64c_pkg::ST_OK};
          job.res[2] = '{b64c_pkg::PAD_CHAR, 1'b0, b64c_pkg::ST_OK};
          job.res[3] = '{b64c_pkg::PAD_CHAR, 1'b1, b64c_pkg::ST_OK};
        end else begin
          job.cnt = (variant == b64c_pkg::VAR_URL) ? 3'd3 : 3'd4;
          job.res[0] = '{b64c_pkg::enc_char(ebits[15:10], variant), 1'b0, b64c_pkg::ST_OK};
          job.res[1] = '{b64c_pkg::enc_char(ebits[9:4], variant), 1'b0, b64c_pkg::ST_OK};
          job.res[2] = '{b64c_pkg::enc_char({ebits[3:0], 2'b00}, variant), variant,
                         b64c_pkg::ST_OK};
          job.res[3] = '{b64c_pkg::PAD_CHAR, 1'b1, b64c_pkg::ST_OK};
        end
        group_bits_next  = '0;
        group_count_next = '0;
        pad_seen_next    = 1'b0;
      end
    end else begin
      if (b == b64c_pkg::PAD_CHAR) begin
        pad_seen_next = 1'b1;
      end else if (dv[6] || pad_seen) begin
        err    = 1'b1;
        err_st = b64c_pkg::ST_BAD_CHAR;
      end else if (group_count == 2'd3) begin
        emitted = 1'b1;
        job.cnt = 3'd3;
        job.res[0] = '{dbits[23:16], 1'b0, b64c_pkg::ST_OK};
        job.res[1] = '{dbits[15:8], 1'b0, b64c_pkg::ST_OK};
        job.res[2] = '{dbits[7:0], last, b64c_pkg::ST_OK};
        group_bits_next  = '0;
        group_count_next = '0;
      end else begin
        group_bits_next  = dbits;
        group_count_next = group_count + 2'd1;
      end

      if (!err && last) begin
        case (group_count_next)
          2'd1: begin
            err    = 1'b1;
            err_st = b64c_pkg::ST_BAD_LEN;
          end
          2'd2: begin
            job.cnt = 3'd1;
            job.res[0] = '{group_bits_next[11:4], 1'b1, b64c_pkg::ST_OK};
          end
          2'd3: begin
            job.cnt = 3'd2;
            job.res[0] = '{group_bits_next[17:10], 1'b0, b64c_pkg::ST_OK};
            job.res[1] = '{group_bits_next[9:2], 1'b1, b64c_pkg::ST_OK};
          end
          default: begin
            // frame ended on padding only: end marker
            if (!emitted) begin
              job.cnt = 3'd1;
              job.res[0] = '{8'h00, 1'b1, b64c_pkg::ST_OK};
            end
          end
        endcase
        group_bits_next  = '0;
        group_count_next = '0;
        pad_seen_next    = 1'b0;
      end

      if (err) begin
        job = '0;
        job.cnt = 3'd1;
        job.res[0] = '{8'h00, 1'b1, err_st};
        group_bits_next  = '0;
        group_count_next = '0;
        pad_seen_next    = 1'b0;
        discarding_next  = !last;
      end
    end
  end

  assign job_push = accept && (job.cnt != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      direction   <= 1'b0;
      variant     <= 1'b0;
      group_bits  <= '0;
      group_count <= '0;
      pad_seen    <= 1'b0;
      discarding  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (cfg_addr == b64c_pkg::CFG_DIRECTION) direction <= cfg_wdata;
        if (cfg_addr == b64c_pkg::CFG_VARIANT)   variant   <= cfg_wdata;
      end
      if (accept) begin
        group_bits  <= group_bits_next;
        group_count <= group_count_next;
        pad_seen    <= pad_seen_next;
        discarding  <= discarding_next;
      end
    end
  end

endmodule

[hw/rtl/b64c_job_fifo.sv]
// ----------------------------------------------------------------------------
// b64c_job_fifo
// Short queue of jobs between the front and the back.
// ----------------------------------------------------------------------------
module b64c_job_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  b64c_pkg::job_t  push_job,
  input  logic            pop,
  output b64c_pkg::job_t  head,
  output logic            full,
  output logic            empty
);

  b64c_pkg::job_t mem [b64c_pkg::JOB_DEPTH];

  logic [b64c_pkg::JOB_PTR_W-1:0] wr_ptr;
  logic [b64c_pkg::JOB_PTR_W-1:0] rd_ptr;
  logic [b64c_pkg::JOB_CNT_W-1:0] count;

  assign full  = (count == b64c_pkg::JOB_CNT_W'(b64c_pkg::JOB_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

[hw/rtl/b64c_back.sv]
// ----------------------------------------------------------------------------
// b64c_back
// Walks the head job one result a cycle into the output register as it frees.
// ----------------------------------------------------------------------------
module b64c_back (
  input  logic               clk,
  input  logic               rst,
  input  b64c_pkg::job_t     head,
  input  logic               job_empty,
  output logic               job_pop,
  input  logic               pop,
  output logic               empty,
  output b64c_pkg::result_t  out_data
);

  logic [b64c_pkg::RES_IDX_W-1:0] idx;
  logic                           out_valid;
  b64c_pkg::result_t              out_q;
  logic                           load;
  logic                           at_end;

  assign load    = !job_empty && (!out_valid || pop);
  assign at_end  = ({1'b0, idx} == head.cnt - 3'd1);
  assign job_pop = load && at_end;
  assign empty   = !out_valid;
  assign out_data = out_q;

  always_ff @(posedge clk) begin
    if (load) out_q <= head.res[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= at_end ? '0 : idx + 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/base64_stream_codec_unit.sv]
// ----------------------------------------------------------------------------
// base64_stream_codec_unit
// Streaming base64 codec, encode or decode, standard or url alphabet.
// ----------------------------------------------------------------------------
// One beat is accepted each cycle while the two-entry job queue has room; a
// beat's results (up to four) pass through the job queue and the output
// register to the result port and leave one per cycle while pop is high, so the
// single output register sets the rate. The user must write the configuration
// through cfg_wr/cfg_addr/cfg_wdata only while the block is idle, which the
// block does not enforce; index 0 is the direction, index 1 the alphabet variant.
module base64_stream_codec_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr,
  input  logic               cfg_addr,
  input  logic               cfg_wdata,
  input  logic               push,
  output logic               full,
  input  b64c_pkg::item_t    in_data,
  output logic               empty,
  input  logic               pop,
  output b64c_pkg::result_t  out_data
);

  logic           accept;
  logic           job_push;
  b64c_pkg::job_t job;
  b64c_pkg::job_t head;
  logic           job_pop;
  logic           job_empty;

  assign accept = push && !full;

  b64c_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_wr),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .item      (in_data),
    .job_push  (job_push),
    .job       (job)
  );

  b64c_job_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (job),
    .pop      (job_pop),
    .head     (head),
    .full     (full),
    .empty    (job_empty)
  );

  b64c_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .pop       (pop),
    .empty     (empty),
    .out_data  (out_data)
  );

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the base64 stream codec: a short directed table,
// then random frames in all four modes, each result beat compared with the
// table's own results or with a behavioural model of the codec in the bench.
// ----------------------------------------------------------------------------
module tb;
  import b64c_pkg::*;

  localparam logic DIR_DECODE = ~DIR_ENCODE;
  localparam logic VAR_STD    = ~VAR_URL;

  localparam bit [8*64-1:0] STD_ALPHA =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam bit [8*64-1:0] URL_ALPHA =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

  // one row of the directed table; typed rows carry their results inline
  typedef struct packed {
    bit        set_cfg;
    bit        dir;
    bit        url;
    bit [7:0]  b;
    bit        last;
    bit        typed;
    bit [2:0]  n_exp;
    bit [31:0] chars;
    bit [1:0]  st;
  } vec_t;

  logic    clk;
  logic    rst       = 1'b1;
  logic    cfg_wr    = 1'b0;
  logic    cfg_addr  = 1'b0;
  logic    cfg_wdata = 1'b0;
  logic    push      = 1'b0;
  logic    pop       = 1'b0;
  logic    full;
  logic    empty;
  item_t   cmd_beat  = '0;
  result_t res_beat;

  // model state
  bit [23:0] acc_bits;
  bit [1:0]  acc_cnt;
  bit        pad_flag;
  bit        drop_flag;
  bit        mode_dir;
  bit        mode_url;

  result_t step_out[$];
  result_t codec_out_q[$];
  vec_t    tbl[$];

  int  bad_cnt   = 0;
  int  sent      = 0;
  int  hold_left = 0;
  bit  quiet     = 1'b0;
  bit  steady    = 1'b0;

  base64_stream_codec_unit uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_wr),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .push      (push),
    .full      (full),
    .in_data   (cmd_beat),
    .empty     (empty),
    .pop       (pop),
    .out_data  (res_beat)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("base64_stream_codec_unit regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------- model

  function automatic bit [7:0] sextet_char(bit [5:0] s);
    return mode_url ? URL_ALPHA[8*(63-s) +: 8] : STD_ALPHA[8*(63-s) +: 8];
  endfunction

  // 64 when the character is outside the selected alphabet
  function automatic int char_sextet(bit [7:0] c);
    int i;
    for (i = 0; i < 64; i++) begin
      if (sextet_char(i[5:0]) == c) return i;
    end
    return 64;
  endfunction

  function automatic void put_out(bit [7:0] b, bit l, bit [1:0] st);
    result_t r;
    r.out_byte = b;
    r.out_last = l;
    r.status   = st;
    step_out.push_back(r);
  endfunction

  function automatic void clear_acc();
    acc_bits = '0;
    acc_cnt  = '0;
    pad_flag = 1'b0;
  endfunction

  function automatic void flag_error(bit last, bit [1:0] st);
    put_out(8'h00, 1'b1, st);
    clear_acc();
    drop_flag = !last;
  endfunction

  function automatic void encode_beat(bit [7:0] b, bit last);
    int        n;
    bit [23:0] bits;
    n    = int'(acc_cnt) + 1;
    bits = {acc_bits[15:0], b};
    if (n >= 3) begin
      put_out(sextet_char(bits[23:18]), 1'b0, ST_OK);
      put_out(sextet_char(bits[17:12]), 1'b0, ST_OK);
      put_out(sextet_char(bits[11:6]), 1'b0, ST_OK);
      put_out(sextet_char(bits[5:0]), last, ST_OK);
      clear_acc();
    end else if (!last) begin
      acc_bits = bits;
      acc_cnt  = n[1:0];
    end else begin
      if (n == 1) begin
        put_out(sextet_char(b[7:2]), 1'b0, ST_OK);
        put_out(sextet_char({b[1:0], 4'b0000}), mode_url, ST_OK);
        if (!mode_url) begin
          put_out(PAD_CHAR, 1'b0, ST_OK);
          put_out(PAD_CHAR, 1'b1, ST_OK);
        end
      end else begin
        put_out(sextet_char(bits[15:10]), 1'b0, ST_OK);
        put_out(sextet_char(bits[9:4]), 1'b0, ST_OK);
        put_out(sextet_char({bits[3:0], 2'b00}), mode_url, ST_OK);
        if (!mode_url) put_out(PAD_CHAR, 1'b1, ST_OK);
      end
      clear_acc();
    end
  endfunction

  function automatic void decode_beat(bit [7:0] c, bit last);
    int v;
    if (c == PAD_CHAR) begin
      pad_flag = 1'b1;
    end else begin
      v = char_sextet(c);
      if (v > 63 || pad_flag) begin
        flag_error(last, ST_BAD_CHAR);
        return;
      end
      acc_bits = {acc_bits[17:0], v[5:0]};
      if (acc_cnt == 2'd3) begin
        put_out(acc_bits[23:16], 1'b0, ST_OK);
        put_out(acc_bits[15:8], 1'b0, ST_OK);
        put_out(acc_bits[7:0], last, ST_OK);
        acc_bits = '0;
        acc_cnt  = '0;
      end else begin
        acc_cnt = acc_cnt + 2'd1;
      end
    end
    if (!last) return;
    case (acc_cnt)
      2'd1: begin
        flag_error(last, ST_BAD_LEN);
        return;
      end
      2'd2: put_out(acc_bits[11:4], 1'b1, ST_OK);
      2'd3: begin
        put_out(acc_bits[17:10], 1'b0, ST_OK);
        put_out(acc_bits[9:2], 1'b1, ST_OK);
      end
      default: begin
        // frame closed on padding alone: end marker only
        if (step_out.size() == 0) put_out(8'h00, 1'b1, ST_OK);
      end
    endcase
    clear_acc();
  endfunction

  function automatic void codec_step(bit [7:0] b, bit last);
    step_out.delete();
    if (drop_flag) begin
      if (last) begin
        drop_flag = 1'b0;
        clear_acc();
      end
    end else if (mode_dir != DIR_ENCODE) begin
      decode_beat(b, last);
    end else begin
      encode_beat(b, last);
    end
  endfunction

  function automatic vec_t row(bit set_cfg, bit dir, bit url, bit [7:0] b, bit last,
                               bit typed, bit [2:0] n, bit [31:0] chars, bit [1:0] st);
    vec_t v;
    v.set_cfg = set_cfg;
    v.dir     = dir;
    v.url     = url;
    v.b       = b;
    v.last    = last;
    v.typed   = typed;
    v.n_exp   = n;
    v.chars   = chars;
    v.st      = st;
    return v;
  endfunction

  // ---------------------------------------------------------------- driving

  task automatic pause();
    if (!quiet && !steady && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic beat(bit [7:0] b, bit last, bit typed, bit [2:0] n, bit [31:0] chars,
                      bit [1:0] st);
    result_t r;
    int      k;
    push             <= 1'b1;
    cmd_beat.in_byte <= b;
    cmd_beat.in_last <= last;
    @(posedge clk);
    while (full) @(posedge clk);
    codec_step(b, last);
    if (!typed) begin
      foreach (step_out[k]) codec_out_q.push_back(step_out[k]);
    end else begin
      for (k = 0; k < n; k++) begin
        r.out_byte = chars[8*(n-1-k) +: 8];
        r.out_last = (k == n - 1);
        r.status   = st;
        codec_out_q.push_back(r);
      end
    end
    sent++;
    pause();
  endtask

  task automatic send(bit [7:0] b, bit last);
    beat(b, last, 1'b0, 3'd0, 32'd0, ST_OK);
  endtask

  // sender holds off until every expected result is out
  task automatic drain();
    push <= 1'b0;
    while (codec_out_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_mode(bit dir, bit url);
    drain();
    cfg_wr    <= 1'b1;
    cfg_addr  <= CFG_DIRECTION;
    cfg_wdata <= dir;
    @(posedge clk);
    mode_dir   = dir;
    cfg_addr  <= CFG_VARIANT;
    cfg_wdata <= url;
    @(posedge clk);
    mode_url   = url;
    cfg_wr    <= 1'b0;
  endtask

  task automatic enc_frame();
    int len;
    int k;
    len = $urandom_range(1, 9);
    for (k = 0; k < len; k++) send(8'($urandom_range(0, 255)), k == len - 1);
  endtask

  task automatic dec_frame();
    bit [7:0] txt[$];
    int       len;
    int       pads;
    int       k;
    len = $urandom_range(1, 11);
    // mostly well-formed lengths, the odd single-sextet tail kept as noise
    if (len % 4 == 1 && $urandom_range(0, 3) != 0) len++;
    for (k = 0; k < len; k++) begin
      if ($urandom_range(0, 15) == 0)
        txt.push_back($urandom_range(0, 1) ? PAD_CHAR : 8'($urandom_range(0, 255)));
      else
        txt.push_back(sextet_char(6'($urandom_range(0, 63))));
    end
    pads = (len % 4 == 2) ? 2 : (len % 4 == 3) ? 1 : 0;
    if (mode_url ? ($urandom_range(0, 5) != 0) : ($urandom_range(0, 3) == 0)) pads = 0;
    repeat (pads) txt.push_back(PAD_CHAR);
    foreach (txt[k]) send(txt[k], k == txt.size() - 1);
  endtask

  task automatic frame();
    if (mode_dir == DIR_ENCODE) enc_frame();
    else dec_frame();
  endtask

  // ---------------------------------------------------------------- result side

  initial begin : sink
    int idle_left;
    int run_left;
    idle_left = 0;
    run_left  = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else if (quiet) begin
        pop <= 1'b1;
      end else if (idle_left > 0) begin
        pop <= 1'b0;
        idle_left--;
      end else if (run_left > 0) begin
        pop <= 1'b1;
        run_left--;
      end else if ($urandom_range(0, 2) == 0) begin
        pop <= 1'b0;
        idle_left = $urandom_range(1, 14) - 1;
      end else begin
        pop <= 1'b1;
        run_left = $urandom_range(1, 24) - 1;
      end
    end
  end

  always @(posedge clk) begin : check
    result_t want;
    if (!rst && pop && !empty) begin
      if (codec_out_q.size() == 0) begin
        bad_cnt++;
        if (bad_cnt <= 10) $display("unexpected result beat: byte %h last %b status %0d",
                                    res_beat.out_byte, res_beat.out_last, res_beat.status);
      end else begin
        want = codec_out_q.pop_front();
        if (res_beat !== want) begin
          bad_cnt++;
          if (bad_cnt <= 10)
            $display("mismatch: want byte %h last %b status %0d, got byte %h last %b status %0d",
                     want.out_byte, want.out_last, want.status,
                     res_beat.out_byte, res_beat.out_last, res_beat.status);
        end
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin : stim
    int ph;
    int n0;
    int i;
    int k;

    mode_dir  = DIR_ENCODE;
    mode_url  = VAR_STD;
    drop_flag = 1'b0;
    clear_acc();

    // encode straight out of reset, then the url alphabet
    tbl.push_back(row(0, DIR_ENCODE, VAR_STD, "M",   1, 1, 4, "TQ==", ST_OK));
    tbl.push_back(row(0, DIR_ENCODE, VAR_STD, "M",   0, 0, 0, 0,      ST_OK));
    tbl.push_back(row(0, DIR_ENCODE, VAR_STD, "a",   1, 1, 4, "TWE=", ST_OK));
    tbl.push_back(row(0, DIR_ENCODE, VAR_STD, 8'h00, 1, 1, 4, "AA==", ST_OK));
    tbl.push_back(row(1, DIR_ENCODE, VAR_URL, 8'hFB, 1, 1, 2, "-w",   ST_OK));
    tbl.push_back(row(0, DIR_ENCODE, VAR_URL, 8'hFF, 0, 0, 0, 0,      ST_OK));
    tbl.push_back(row(0, DIR_ENCODE, VAR_URL, 8'hFF, 1, 1, 3, "__8",  ST_OK));
    // decode: padded tail, bad characters, short tail, discard to frame end
    tbl.push_back(row(1, DIR_DECODE, VAR_STD, "T",   0, 0, 0, 0,      ST_OK));
    tbl.push_back(row(0, DIR_DECODE, VAR_STD, "W",   0, 0, 0, 0,      ST_OK));
    tbl.push_back(row(0, DIR_DECODE, VAR_STD, "E",   0, 0, 0, 0,      ST_OK));
    tbl.push_back(row(0, DIR_DECODE, VAR_STD, "=",   1, 1, 2, "Ma",   ST_OK));
    tbl.push_back(row(0, DIR_DECODE, VAR_STD, "*",   1, 1, 1, 0,      ST_BAD_CHAR));
    tbl.push_back(row(0, DIR_DECODE, VAR_STD, "Q",   1, 1, 1, 0,      ST_BAD_LEN));
    tbl.push_back(row(0, DIR_DECODE, VAR_STD, "=",   0, 0, 0, 0,      ST_OK));
    tbl.push_back(row(0, DIR_DECODE, VAR_STD, "A",   1, 1, 1, 0,      ST_BAD_CHAR));
    tbl.push_back(row(0, DIR_DECODE, VAR_STD, "!",   0, 1, 1, 0,      ST_BAD_CHAR));
    tbl.push_back(row(0, DIR_DECODE, VAR_STD, "B",   1, 0, 0, 0,      ST_OK));
    tbl.push_back(row(0, DIR_DECODE, VAR_STD, "=",   1, 1, 1, 0,      ST_OK));
    tbl.push_back(row(1, DIR_DECODE, VAR_URL, "_",   0, 0, 0, 0,      ST_OK));
    tbl.push_back(row(0, DIR_DECODE, VAR_URL, "_",   0, 0, 0, 0,      ST_OK));
    tbl.push_back(row(0, DIR_DECODE, VAR_URL, "8",   1, 1, 2, 16'hFFFF, ST_OK));
    tbl.push_back(row(0, DIR_DECODE, VAR_URL, "+",   1, 1, 1, 0,      ST_BAD_CHAR));
    // partial decode group carried into encode mode
    tbl.push_back(row(1, DIR_DECODE, VAR_STD, "Q",   0, 0, 0, 0,      ST_OK));
    tbl.push_back(row(0, DIR_DECODE, VAR_STD, "Q",   0, 0, 0, 0,      ST_OK));
    tbl.push_back(row(1, DIR_ENCODE, VAR_STD, "A",   1, 0, 0, 0,      ST_OK));

    rst <= 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < tbl.size(); i++) begin
      if (tbl[i].set_cfg) set_mode(tbl[i].dir, tbl[i].url);
      beat(tbl[i].b, tbl[i].last, tbl[i].typed, tbl[i].n_exp, tbl[i].chars, tbl[i].st);
    end

    // random frames over every mode; odd phases stop mid-frame before the switch
    for (ph = 0; ph < 6; ph++) begin
      set_mode((ph % 4) >= 2 ? DIR_DECODE : DIR_ENCODE, (ph % 2) ? VAR_URL : VAR_STD);
      n0 = sent;
      while (sent - n0 < 6) frame();
      if (ph % 2) begin
        for (k = $urandom_range(1, 3); k > 0; k--) begin
          if (mode_dir == DIR_ENCODE) send(8'($urandom_range(0, 255)), 1'b0);
          else send(sextet_char(6'($urandom_range(0, 63))), 1'b0);
        end
      end
    end

    // receiver stalls long while encode beats keep coming: input backs up
    set_mode(DIR_ENCODE, 1'($urandom_range(0, 1)));
    steady    = 1'b1;
    hold_left = 300;
    n0 = sent;
    while (sent - n0 < 12) enc_frame();
    steady = 1'b0;

    // closing stretch with no idling on either side
    set_mode(DIR_DECODE, VAR_STD);
    quiet = 1'b1;
    n0 = sent;
    while (sent - n0 < 8) dec_frame();
    set_mode(DIR_ENCODE, VAR_URL);
    n0 = sent;
    while (sent - n0 < 6) enc_frame();

    push <= 1'b0;
    while (codec_out_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (bad_cnt == 0 && codec_out_q.size() == 0) begin
      $display("base64_stream_codec_unit regression: pass");
    end else begin
      $display("base64_stream_codec_unit regression: fail");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/b64c_pkg.sv
hw/rtl/b64c_front.sv
hw/rtl/b64c_job_fifo.sv
hw/rtl/b64c_back.sv
hw/rtl/base64_stream_codec_unit.sv
verif/tb.sv
